[src/mahs_pkg.sv]
// shared types, decode tables and header field helpers for the mpeg audio header scanner
// no dependencies; used by every module in src

package mahs_pkg;

	// result status codes
	localparam logic [1:0] ST_DECODED   = 2'd0;
	localparam logic [1:0] ST_NO_HEADER = 2'd1;
	localparam logic [1:0] ST_EARLY_END = 2'd2;

	// stream constants
	localparam logic [10:0] SYNC_ALL  = 11'd2047;
	localparam logic [31:0] XING_WORD = 32'h5869_6E67;
	localparam logic [23:0] ID3_WORD  = 24'h49_4433;
	localparam logic [31:0] FRAMES_NONE = 32'hFFFF_FFFF;
	localparam logic [31:0] FRAMES_MAX  = 32'h7FFF_FFFF;

	// side-info distances
	localparam logic [5:0] SIDE_V1_MONO   = 6'd17;
	localparam logic [5:0] SIDE_V1_STEREO = 6'd32;
	localparam logic [5:0] SIDE_V2_MONO   = 6'd9;
	localparam logic [5:0] SIDE_V2_STEREO = 6'd17;

	// queue between the scanner and the decoder
	localparam int QUEUE_DEPTH = 2;

	// bitrate table, indexed by version lsb, layer index minus one, bitrate index
	localparam logic [8:0] KBPS_TAB [2][3][16] = '{
		'{
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
		}
	};

	// sample rate table, indexed by version index and frequency index
	localparam logic [15:0] RATE_TAB [4][3] = '{
		'{16'd11025, 16'd12000, 16'd8000},
		'{16'd0, 16'd0, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000},
		'{16'd44100, 16'd48000, 16'd32000}
	};

	// one input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	// one decoded result
	typedef struct packed {
		logic [1:0]         status;
		logic [27:0]        id3_size;
		logic [31:0]        header_offset;
		logic [1:0]         version_index;
		logic [1:0]         layer;
		logic [8:0]         bitrate_kbps;
		logic [15:0]        sample_rate_hz;
		logic [1:0]         channel_mode;
		logic               protection;
		logic               vbr;
		logic signed [31:0] vbr_frames;
	} res_item_t;

	// raw scan outcome handed from the scanner to the decoder
	typedef struct packed {
		logic [1:0]  status;
		logic [27:0] tag_size;
		logic [31:0] offset;
		logic [31:0] header;
		logic        vbr;
		logic [31:0] frames;
	} scan_evt_t;

	// frame header validity rules
	function automatic logic header_ok(input logic [31:0] h);
		logic [3:0] br;
		br = h[15:12];
		return (h[31:21] == SYNC_ALL) && (h[20:19] != 2'd1) && (h[18:17] != 2'd0) &&
			(br != 4'd0) && (br != 4'd15) && (h[11:10] != 2'd3) && (h[1:0] != 2'd2);
	endfunction

endpackage

[src/mpeg_audio_header_scanner.sv]
// mpeg audio header scanner: one file byte per transfer, one result per file
// throughput: one byte per cycle while the queue is not full; the scanner steps its phase once per byte
// result path: the byte transfer that ends a result writes its event into the queue, then the
// event moves to the output register, where res_valid rises; a stalled output holds it in the queue
// reset: arst_n clears the scanner to the tag check phase and empties queue and output
// depends on mahs_pkg, mahs_front, mahs_queue, mahs_back

module mpeg_audio_header_scanner import mahs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       res_valid,
	input  logic       res_stall,
	output res_item_t  res_item
);

	logic      q_full;
	logic      q_empty;
	logic      evt_push;
	logic      evt_pop;
	scan_evt_t evt;
	scan_evt_t head_evt;

	// byte scanner
	mahs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.evt_push   (evt_push),
		.evt        (evt)
	);

	// event queue
	mahs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (evt_push),
		.push_evt (evt),
		.pop      (evt_pop),
		.head_evt (head_evt),
		.full     (q_full),
		.empty    (q_empty)
	);

	// field decoder and output register
	mahs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_evt  (head_evt),
		.empty     (q_empty),
		.pop       (evt_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

[src/mahs_front.sv]
// scanner front end: id3 tag size, header search, side-info skip and xing probe
// depends on mahs_pkg; pushes one scan event per finished file into the queue

module mahs_front import mahs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	input  logic       q_full,
	output logic       evt_push,
	output scan_evt_t  evt
);

	// phase codes
	localparam logic [2:0] PH_ID3  = 3'd0;
	localparam logic [2:0] PH_TAG  = 3'd1;
	localparam logic [2:0] PH_SCAN = 3'd2;
	localparam logic [2:0] PH_SKIP = 3'd3;
	localparam logic [2:0] PH_XING = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	logic [31:0] pos_q;
	logic [2:0]  phase_q;
	logic [31:0] window_q;
	logic [27:0] tag_q;
	logic [31:0] held_q;
	logic [31:0] found_q;
	logic [5:0]  skip_q;
	logic [31:0] flags_q;
	logic        xok_q;

	logic [31:0] win_nx;
	logic [2:0]  phase_nx;
	logic [27:0] tag_nx;
	logic [31:0] held_nx;
	logic [31:0] found_nx;
	logic [5:0]  skip_nx;
	logic [31:0] flags_nx;
	logic        xok_nx;
	logic [31:0] pos_m3;
	logic [5:0]  skip_inc;
	logic        emit;
	logic [1:0]  emit_status;
	logic        emit_vbr;
	logic [31:0] emit_frames;
	logic        accept;

	// the queue takes at most one event per byte
	assign byte_stall = q_full;
	assign accept     = byte_valid & ~q_full;

	assign win_nx   = {window_q[23:0], byte_item.data_byte};
	assign pos_m3   = pos_q - 32'd3;
	assign skip_inc = skip_q + 6'd1;

	// per-byte phase step
	always_comb begin
		phase_nx    = phase_q;
		tag_nx      = tag_q;
		held_nx     = held_q;
		found_nx    = found_q;
		skip_nx     = skip_q;
		flags_nx    = flags_q;
		xok_nx      = xok_q;
		emit        = 1'b0;
		emit_status = ST_DECODED;
		emit_vbr    = 1'b0;
		emit_frames = FRAMES_NONE;
		unique case (phase_q)
			PH_ID3: begin
				if (pos_q == 32'd2) begin
					phase_nx = (win_nx[23:0] == ID3_WORD) ? PH_TAG : PH_SCAN;
				end
			end
			PH_TAG: begin
				if (pos_q == 32'd9) begin
					tag_nx   = {win_nx[30:24], win_nx[22:16], win_nx[14:8], win_nx[6:0]};
					phase_nx = PH_SCAN;
				end
			end
			PH_SCAN: begin
				if (pos_m3 >= {4'd0, tag_q} && header_ok(win_nx)) begin
					held_nx  = win_nx;
					found_nx = pos_m3;
					if (win_nx[20:19] == 2'd3) begin
						skip_nx = (win_nx[7:6] == 2'd3) ? SIDE_V1_MONO : SIDE_V1_STEREO;
					end else begin
						skip_nx = (win_nx[7:6] == 2'd3) ? SIDE_V2_MONO : SIDE_V2_STEREO;
					end
					phase_nx = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (skip_q != 6'd0) begin
					skip_nx = skip_q - 6'd1;
				end
				if (skip_nx == 6'd0) begin
					phase_nx = PH_XING;
				end
			end
			PH_XING: begin
				skip_nx = skip_inc;
				if (skip_inc == 6'd4) begin
					xok_nx = (win_nx == XING_WORD);
				end else if (skip_inc == 6'd8) begin
					flags_nx = win_nx;
				end else if (skip_inc >= 6'd12) begin
					emit     = 1'b1;
					emit_vbr = xok_q;
					if (xok_q && flags_q[0]) begin
						emit_frames = win_nx[31] ? FRAMES_MAX : win_nx;
					end
					phase_nx = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		// end of file forces a status result unless one went out already
		if (byte_item.last && !emit && phase_nx != PH_DONE) begin
			emit        = 1'b1;
			emit_status = (phase_nx <= PH_SCAN) ? ST_NO_HEADER : ST_EARLY_END;
			emit_vbr    = 1'b0;
			emit_frames = FRAMES_NONE;
		end
	end

	// event to the queue
	assign evt_push     = accept & emit;
	assign evt.status   = emit_status;
	assign evt.tag_size = tag_nx;
	assign evt.offset   = found_nx;
	assign evt.header   = held_nx;
	assign evt.vbr      = emit_vbr;
	assign evt.frames   = emit_frames;

	// scanner state, back to reset after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_ID3;
			window_q <= '0;
			tag_q    <= '0;
			held_q   <= '0;
			found_q  <= '0;
			skip_q   <= '0;
			flags_q  <= '0;
			xok_q    <= 1'b0;
		end else if (accept) begin
			if (byte_item.last) begin
				pos_q    <= '0;
				phase_q  <= PH_ID3;
				window_q <= '0;
				tag_q    <= '0;
				held_q   <= '0;
				found_q  <= '0;
				skip_q   <= '0;
				flags_q  <= '0;
				xok_q    <= 1'b0;
			end else begin
				pos_q    <= pos_q + 32'd1;
				phase_q  <= phase_nx;
				window_q <= win_nx;
				tag_q    <= tag_nx;
				held_q   <= held_nx;
				found_q  <= found_nx;
				skip_q   <= skip_nx;
				flags_q  <= flags_nx;
				xok_q    <= xok_nx;
			end
		end
	end

endmodule

[src/mahs_queue.sv]
// short event queue between scanner and decoder
// depends on mahs_pkg for the event type and depth

module mahs_queue import mahs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  scan_evt_t push_evt,
	input  logic      pop,
	output scan_evt_t head_evt,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	scan_evt_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_evt = slot_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_evt;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/mahs_back.sv]
// decoder back end: header field tables and the result output register
// depends on mahs_pkg for tables and types

module mahs_back import mahs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_evt_t head_evt,
	input  logic      empty,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	logic      res_valid_q;
	res_item_t res_item_q;
	res_item_t dec;
	logic [1:0] ver;
	logic [1:0] lay;
	logic [1:0] fr;
	logic [3:0] br;
	logic [1:0] lay_m1;

	assign ver    = head_evt.header[20:19];
	assign lay    = head_evt.header[18:17];
	assign fr     = head_evt.header[11:10];
	assign br     = head_evt.header[15:12];
	assign lay_m1 = lay - 2'd1;

	// field decode from the held header
	always_comb begin
		dec.status   = head_evt.status;
		dec.id3_size = head_evt.tag_size;
		if (head_evt.status == ST_NO_HEADER) begin
			dec.header_offset  = '0;
			dec.version_index  = '0;
			dec.layer          = '0;
			dec.bitrate_kbps   = '0;
			dec.sample_rate_hz = '0;
			dec.channel_mode   = '0;
			dec.protection     = 1'b0;
			dec.vbr            = 1'b0;
			dec.vbr_frames     = FRAMES_NONE;
		end else begin
			dec.header_offset  = head_evt.offset;
			dec.version_index  = ver;
			dec.layer          = 2'd0 - lay;
			dec.bitrate_kbps   = (lay != 2'd0) ? KBPS_TAB[ver[0]][lay_m1][br] : 9'd0;
			dec.sample_rate_hz = (fr != 2'd3) ? RATE_TAB[ver][fr] : 16'd0;
			dec.channel_mode   = head_evt.header[7:6];
			dec.protection     = head_evt.header[16];
			dec.vbr            = head_evt.vbr;
			dec.vbr_frames     = head_evt.frames;
		end
	end

	// pull the next event when the output register is free or being drained
	assign pop       = ~empty & (~res_valid_q | ~res_stall);
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_item_q <= dec;
		end
	end

endmodule

[verif/mpeg_audio_header_scanner_test.sv]
// self-checking testbench for mpeg_audio_header_scanner: feeds files of bytes,
// checks one result per file; the scoreboard holds its own scanner model
// depends on mahs_pkg and the src rtl

module mpeg_audio_header_scanner_test;
	import mahs_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int REPORT_MAX   = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_FROM   = 300;
	localparam int QUIET_TO     = 600;
	localparam int BYTE_TARGET  = 900;
	localparam int FILE_TARGET  = 36;
	localparam logic [31:0] INFO_WORD = 32'h496E_666F;

	typedef enum logic [2:0] {
		SCAN_ID3, SCAN_TAG, SCAN_SYNC, SCAN_SKIP, SCAN_XING, SCAN_DONE
	} scan_phase_t;

	typedef enum logic [1:0] {FILE_WHOLE, FILE_CUT, FILE_NOISE} file_shape_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_item = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_item_t  res_item;

	mpeg_audio_header_scanner i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	byte_item_t byte_queue[$];
	res_item_t  expected_results[$];
	logic [7:0] file_buf[$];
	bit         byte_fire;
	int         files_planned, bytes_sent, results_seen, mismatches, cycles;
	int         decoded_cnt, no_header_cnt, early_end_cnt, xing_cnt, capped_cnt;

	// scanner model state
	logic [31:0] fp_pos, fp_window, fp_header, fp_offset, fp_flags;
	logic [27:0] fp_tag;
	logic [5:0]  fp_skip;
	logic        fp_xing;
	scan_phase_t fp_phase;

	function automatic void file_restart();
		fp_pos    = '0;
		fp_window = '0;
		fp_header = '0;
		fp_offset = '0;
		fp_flags  = '0;
		fp_tag    = '0;
		fp_skip   = '0;
		fp_xing   = 1'b0;
		fp_phase  = SCAN_ID3;
	endfunction

	// frame header validity rules
	function automatic bit sync_valid(input logic [31:0] h);
		return h[31:21] == SYNC_ALL && h[20:19] != 2'd1 && h[18:17] != 2'd0 &&
			h[15:12] != 4'd0 && h[15:12] != 4'd15 && h[11:10] != 2'd3 && h[1:0] != 2'd2;
	endfunction

	// result fields from the held header
	function automatic res_item_t frame_result(input logic [1:0] st, input logic found,
			input logic [31:0] frames);
		res_item_t  r;
		logic [1:0] ver, lay, fr;
		r = '0;
		r.status = st;
		r.id3_size = fp_tag;
		r.vbr_frames = frames;
		if (st != ST_NO_HEADER) begin
			ver = fp_header[20:19];
			lay = fp_header[18:17];
			fr  = fp_header[11:10];
			r.header_offset  = fp_offset;
			r.version_index  = ver;
			// layer number is four minus the layer index
			r.layer          = 2'd0 - lay;
			r.bitrate_kbps   = KBPS_TAB[ver[0]][lay - 2'd1][fp_header[15:12]];
			r.sample_rate_hz = RATE_TAB[ver][fr];
			r.channel_mode   = fp_header[7:6];
			r.protection     = fp_header[16];
			r.vbr            = found;
		end
		return r;
	endfunction

	// advance the scanner by one byte, returns 1 when the byte yields a result
	function automatic bit scan_byte(input byte_item_t it, output res_item_t r);
		logic [31:0] p;
		logic [31:0] frames;
		bit          got;
		got = 1'b0;
		r = '0;
		p = fp_pos;
		fp_window = {fp_window[23:0], it.data_byte};
		case (fp_phase)
			SCAN_ID3: begin
				if (p == 32'd2)
					fp_phase = (fp_window[23:0] == ID3_WORD) ? SCAN_TAG : SCAN_SYNC;
			end
			SCAN_TAG: begin
				// synchsafe size, top bit of each byte dropped
				if (p == 32'd9) begin
					fp_tag = {fp_window[30:24], fp_window[22:16], fp_window[14:8], fp_window[6:0]};
					fp_phase = SCAN_SYNC;
				end
			end
			SCAN_SYNC: begin
				if (p - 32'd3 >= {4'd0, fp_tag} && sync_valid(fp_window)) begin
					fp_header = fp_window;
					fp_offset = p - 32'd3;
					if (fp_window[20:19] == 2'd3)
						fp_skip = (fp_window[7:6] == 2'd3) ? SIDE_V1_MONO : SIDE_V1_STEREO;
					else
						fp_skip = (fp_window[7:6] == 2'd3) ? SIDE_V2_MONO : SIDE_V2_STEREO;
					fp_phase = SCAN_SKIP;
				end
			end
			SCAN_SKIP: begin
				if (fp_skip != 6'd0)
					fp_skip = fp_skip - 6'd1;
				if (fp_skip == 6'd0)
					fp_phase = SCAN_XING;
			end
			SCAN_XING: begin
				fp_skip = fp_skip + 6'd1;
				if (fp_skip == 6'd4) begin
					fp_xing = (fp_window == XING_WORD);
				end else if (fp_skip == 6'd8) begin
					fp_flags = fp_window;
				end else if (fp_skip >= 6'd12) begin
					frames = FRAMES_NONE;
					if (fp_xing && fp_flags[0])
						frames = (fp_window > FRAMES_MAX) ? FRAMES_MAX : fp_window;
					r = frame_result(ST_DECODED, fp_xing, frames);
					got = 1'b1;
					fp_phase = SCAN_DONE;
				end
			end
			default: ;
		endcase
		fp_pos = p + 32'd1;
		// final byte of the file always reports unless already reported
		if (it.last) begin
			if (!got && fp_phase != SCAN_DONE) begin
				if (fp_phase == SCAN_ID3 || fp_phase == SCAN_TAG || fp_phase == SCAN_SYNC)
					r = frame_result(ST_NO_HEADER, 1'b0, FRAMES_NONE);
				else
					r = frame_result(ST_EARLY_END, 1'b0, FRAMES_NONE);
				got = 1'b1;
			end
			file_restart();
		end
		return got;
	endfunction

	function automatic bit field_differs(input string name, input logic [31:0] e,
			input logic [31:0] a, input bit loud);
		if (a !== e) begin
			if (loud)
				$display("result %0d %s: expected 0x%0h, got 0x%0h", results_seen, name, e, a);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit result_differs(input res_item_t e, input res_item_t a);
		bit bad;
		bit loud;
		bad = 1'b0;
		loud = mismatches < REPORT_MAX;
		bad |= field_differs("status", 32'(e.status), 32'(a.status), loud);
		bad |= field_differs("id3_size", 32'(e.id3_size), 32'(a.id3_size), loud);
		bad |= field_differs("header_offset", e.header_offset, a.header_offset, loud);
		bad |= field_differs("version_index", 32'(e.version_index), 32'(a.version_index),
			loud);
		bad |= field_differs("layer", 32'(e.layer), 32'(a.layer), loud);
		bad |= field_differs("bitrate_kbps", 32'(e.bitrate_kbps), 32'(a.bitrate_kbps), loud);
		bad |= field_differs("sample_rate_hz", 32'(e.sample_rate_hz), 32'(a.sample_rate_hz),
			loud);
		bad |= field_differs("channel_mode", 32'(e.channel_mode), 32'(a.channel_mode), loud);
		bad |= field_differs("protection", 32'(e.protection), 32'(a.protection), loud);
		bad |= field_differs("vbr", 32'(e.vbr), 32'(a.vbr), loud);
		bad |= field_differs("vbr_frames", e.vbr_frames, a.vbr_frames, loud);
		return bad;
	endfunction

	// random idling, none at all inside the quiet stretch
	function automatic bit take_break();
		if (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 15;
	endfunction

	// monitor: byte transfers feed the model, result transfers are checked
	always @(posedge clk) begin : monitor
		res_item_t want;
		byte_fire = arst_n && byte_valid && !byte_stall;
		if (byte_fire) begin
			bytes_sent++;
			if (scan_byte(byte_item, want))
				expected_results.push_back(want);
		end
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("result %0d arrived with none expected: %p", results_seen, res_item);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (result_differs(want, res_item))
					mismatches++;
				case (want.status)
					ST_DECODED:   decoded_cnt++;
					ST_NO_HEADER: no_header_cnt++;
					default:      early_end_cnt++;
				endcase
				if (want.vbr)
					xing_cnt++;
				if (want.vbr_frames == FRAMES_MAX)
					capped_cnt++;
			end
		end
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver: holds a stalled transfer, otherwise moves on or idles
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			res_stall <= 1'b0;
		end else begin
			if (!byte_valid || byte_fire) begin
				if (byte_queue.size() != 0 && !take_break()) begin
					byte_item <= byte_queue.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
			res_stall <= take_break();
		end
	end

	task automatic put_word(input logic [31:0] w);
		file_buf.push_back(w[31:24]);
		file_buf.push_back(w[23:16]);
		file_buf.push_back(w[15:8]);
		file_buf.push_back(w[7:0]);
	endtask

	// queue the first bytes of the file buffer, marking the final one
	task automatic close_file(input int unsigned keep);
		byte_item_t it;
		for (int unsigned i = 0; i < keep; i++) begin
			it.data_byte = file_buf[i];
			it.last = (i == keep - 1);
			byte_queue.push_back(it);
		end
		file_buf.delete();
		files_planned++;
	endtask

	function automatic logic [31:0] pick_header();
		logic [31:0] h;
		int unsigned v;
		h = $urandom;
		h[31:21] = SYNC_ALL;
		v = $urandom_range(0, 2);
		h[20:19] = (v == 0) ? 2'd0 : (v == 1) ? 2'd2 : 2'd3;
		h[18:17] = 2'($urandom_range(1, 3));
		h[15:12] = 4'($urandom_range(1, 14));
		h[11:10] = 2'($urandom_range(0, 2));
		v = $urandom_range(0, 2);
		h[1:0] = (v == 2) ? 2'd3 : 2'(v);
		return h;
	endfunction

	// a header that breaks exactly one validity rule
	function automatic logic [31:0] spoil_header(input logic [31:0] h);
		case ($urandom_range(0, 5))
			0: h[21 + $urandom_range(0, 10)] = 1'b0;
			1: h[20:19] = 2'd1;
			2: h[18:17] = 2'd0;
			3: h[15:12] = $urandom_range(0, 1) ? 4'd15 : 4'd0;
			4: h[11:10] = 2'd3;
			default: h[1:0] = 2'd2;
		endcase
		return h;
	endfunction

	task automatic put_filler(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 6) == 0)
				put_word(spoil_header(pick_header()));
			else
				file_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// one random file: whole or cut short stream, or plain noise
	task automatic gen_file(input file_shape_t shape);
		logic [31:0] h;
		logic [27:0] tsz;
		int unsigned pad, side_len;
		if (shape == FILE_NOISE) begin
			case ($urandom_range(0, 3))
				0: begin
					file_buf.push_back(ID3_WORD[23:16]);
					file_buf.push_back(ID3_WORD[15:8]);
					file_buf.push_back(8'($urandom_range(0, 255)));
				end
				1: put_word({ID3_WORD, 8'($urandom_range(0, 255))});
				default: ;
			endcase
			put_filler($urandom_range(1, 20));
			close_file(file_buf.size());
			return;
		end
		pad = 0;
		if ($urandom_range(0, 2) == 0) begin
			tsz = ($urandom_range(0, 3) == 0) ? 28'($urandom_range(0, 9)) :
				28'($urandom_range(10, 30));
			put_word({ID3_WORD, 8'($urandom_range(0, 255))});
			file_buf.push_back(8'($urandom_range(0, 255)));
			file_buf.push_back(8'($urandom_range(0, 255)));
			put_word({1'($urandom), tsz[27:21], 1'($urandom), tsz[20:14],
				1'($urandom), tsz[13:7], 1'($urandom), tsz[6:0]});
			pad = (tsz > 10) ? tsz - 10 : 0;
		end
		put_filler(pad + $urandom_range(0, 4));
		h = pick_header();
		put_word(h);
		// side info, then the xing probe bytes
		if (h[20:19] == 2'd3)
			side_len = 32'((h[7:6] == 2'd3) ? SIDE_V1_MONO : SIDE_V1_STEREO);
		else
			side_len = 32'((h[7:6] == 2'd3) ? SIDE_V2_MONO : SIDE_V2_STEREO);
		for (int unsigned i = 0; i < side_len; i++)
			file_buf.push_back(8'($urandom_range(0, 255)));
		case ($urandom_range(0, 4))
			0: put_word($urandom);
			1: put_word(INFO_WORD);
			default: put_word(XING_WORD);
		endcase
		put_word($urandom);
		put_word($urandom);
		put_filler($urandom_range(0, 4));
		close_file(shape == FILE_CUT ? $urandom_range(1, file_buf.size()) : file_buf.size());
	endtask

	initial begin : stimulus
		int unsigned pick;
		file_restart();

		// lone sync byte
		file_buf.push_back(8'hFF);
		close_file(1);
		// mpeg 2.5 layer I mono header completed by the final byte
		put_word({SYNC_ALL, 2'd0, 2'd3, 1'b1, 4'd14, 2'd2, 1'b0, 1'b1, 2'd3, 2'd0,
			1'b1, 1'b0, 2'd3});
		close_file(4);
		// tag header with every size bit set, file ends before any scan
		put_word({ID3_WORD, 8'hFF});
		put_word(32'hFFFF_FFFF);
		file_buf.push_back(8'hFF);
		file_buf.push_back(8'hFF);
		close_file(10);
		// tag marker cut short
		put_word({ID3_WORD, 8'h00});
		close_file(3);
		// partial window only
		file_buf.push_back(8'hFF);
		file_buf.push_back(8'hFB);
		close_file(2);

		// random files, mostly well formed
		while (byte_queue.size() < BYTE_TARGET || files_planned < FILE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				gen_file(FILE_WHOLE);
			else if (pick < 75)
				gen_file(FILE_CUT);
			else
				gen_file(FILE_NOISE);
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || byte_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d files in %0d bytes gave %0d results: %0d decoded,",
			files_planned, bytes_sent, results_seen, decoded_cnt);
		$display("%0d without header, %0d cut short, %0d with a xing tag,",
			no_header_cnt, early_end_cnt, xing_cnt);
		$display("%0d frame counts at the cap, %0d mismatching results", capped_cnt, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
